### sv/eds_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// eds_pkg
// Shared widths and the record that travels down the square-root chain.
// ----------------------------------------------------------------------------
package eds_pkg;

  localparam int ELEMENT_WIDTH = 16;
  localparam int SUM_WIDTH     = 48;
  localparam int DIST_WIDTH    = 24;

  // Magnitude of a difference needs one bit more than an element.
  localparam int MAG_WIDTH  = ELEMENT_WIDTH + 1;
  localparam int SQ_WIDTH   = 2 * MAG_WIDTH;
  localparam int ACC_WIDTH  = ((SUM_WIDTH > SQ_WIDTH) ? SUM_WIDTH : SQ_WIDTH) + 1;

  // One chain cell per root bit; each cell consumes two radicand bits.
  localparam int ROOT_WIDTH     = (SUM_WIDTH + 1) / 2;
  localparam int RAD_WIDTH      = 2 * ROOT_WIDTH;
  localparam int REM_WIDTH      = ROOT_WIDTH + 2;
  localparam int DIST_EXT_WIDTH = (ROOT_WIDTH > DIST_WIDTH) ? ROOT_WIDTH : DIST_WIDTH;

  typedef struct packed {
    logic                  valid;
    logic                  sat;
    logic [RAD_WIDTH-1:0]  rad;
    logic [REM_WIDTH-1:0]  rem;
    logic [ROOT_WIDTH-1:0] root;
  } cell_t;

endpackage
`default_nettype wire

### sv/eds_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// eds_in_if
// Element pair channel: valid/ready handshake with the two elements.
// ----------------------------------------------------------------------------
interface eds_in_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [eds_pkg::ELEMENT_WIDTH-1:0] elem_a;
  logic signed [eds_pkg::ELEMENT_WIDTH-1:0] elem_b;
  logic                                    last_element;

  modport source (output valid, output elem_a, output elem_b, output last_element,
                  input ready);
  modport sink (input valid, input elem_a, input elem_b, input last_element,
                output ready);
endinterface
`default_nettype wire

### sv/eds_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// eds_out_if
// Result channel: valid/ready handshake with distance and saturation flag.
// ----------------------------------------------------------------------------
interface eds_out_if;
  logic                            valid;
  logic                            ready;
  logic [eds_pkg::DIST_WIDTH-1:0]  distance;
  logic                            saturated;

  modport source (output valid, output distance, output saturated, input ready);
  modport sink (input valid, input distance, input saturated, output ready);
endinterface
`default_nettype wire

### sv/eds_accum.sv
`default_nettype none
// ----------------------------------------------------------------------------
// eds_accum
// Difference, square and saturating accumulate; launches the sum on last.
// ----------------------------------------------------------------------------
module eds_accum (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  input  wire logic                                     en,
  input  wire logic                                     in_valid,
  input  wire logic signed [eds_pkg::ELEMENT_WIDTH-1:0] elem_a,
  input  wire logic signed [eds_pkg::ELEMENT_WIDTH-1:0] elem_b,
  input  wire logic                                     last_element,
  output eds_pkg::cell_t                                launch
);

  logic                            mag_valid;
  logic                            mag_last;
  logic [eds_pkg::MAG_WIDTH-1:0]   mag;
  logic                            sq_valid;
  logic                            sq_last;
  logic [eds_pkg::SQ_WIDTH-1:0]    sq;
  logic [eds_pkg::SUM_WIDTH-1:0]   sum;
  logic                            ovf_seen;

  logic signed [eds_pkg::MAG_WIDTH-1:0] diff;
  logic [eds_pkg::MAG_WIDTH-1:0]        mag_next;
  logic [eds_pkg::ACC_WIDTH-1:0]        acc;
  logic                                 ovf;
  logic [eds_pkg::SUM_WIDTH-1:0]        sum_next;
  logic                                 ovf_next;

  always_comb begin
    diff = eds_pkg::MAG_WIDTH'(elem_a) - eds_pkg::MAG_WIDTH'(elem_b);
    mag_next = diff[eds_pkg::MAG_WIDTH-1] ? eds_pkg::MAG_WIDTH'(-diff)
                                          : eds_pkg::MAG_WIDTH'(diff);
    acc = eds_pkg::ACC_WIDTH'(sum) + eds_pkg::ACC_WIDTH'(sq);
    ovf = (acc >> eds_pkg::SUM_WIDTH) != '0;
    sum_next = ovf ? '1 : acc[eds_pkg::SUM_WIDTH-1:0];
    ovf_next = ovf_seen | ovf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mag_valid    <= 1'b0;
      sq_valid     <= 1'b0;
      launch.valid <= 1'b0;
      sum          <= '0;
      ovf_seen     <= 1'b0;
    end else if (en) begin
      mag_valid    <= in_valid;
      sq_valid     <= mag_valid;
      launch.valid <= sq_valid & sq_last;
      if (sq_valid) begin
        if (sq_last) begin
          sum      <= '0;
          ovf_seen <= 1'b0;
        end else begin
          sum      <= sum_next;
          ovf_seen <= ovf_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag         <= mag_next;
      mag_last    <= last_element;
      sq          <= eds_pkg::SQ_WIDTH'(mag) * eds_pkg::SQ_WIDTH'(mag);
      sq_last     <= mag_last;
      launch.sat  <= ovf_next;
      launch.rad  <= eds_pkg::RAD_WIDTH'(sum_next);
      launch.rem  <= '0;
      launch.root <= '0;
    end
  end

endmodule
`default_nettype wire

### sv/eds_sqrt_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// eds_sqrt_cell
// One restoring square-root step: settles one root bit from two radicand bits.
// ----------------------------------------------------------------------------
module eds_sqrt_cell (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  en,
  input  wire eds_pkg::cell_t prev,
  output eds_pkg::cell_t next
);

  logic [eds_pkg::REM_WIDTH-1:0] rem_sh;
  logic [eds_pkg::REM_WIDTH-1:0] trial;
  logic                          take;

  always_comb begin
    rem_sh = {prev.rem[eds_pkg::REM_WIDTH-3:0],
              prev.rad[eds_pkg::RAD_WIDTH-1 -: 2]};
    trial  = {prev.root, 2'b01};
    take   = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next.valid <= 1'b0;
    end else if (en) begin
      next.valid <= prev.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      next.sat  <= prev.sat;
      next.rad  <= prev.rad << 2;
      next.rem  <= take ? rem_sh - trial : rem_sh;
      next.root <= {prev.root[eds_pkg::ROOT_WIDTH-2:0], take};
    end
  end

endmodule
`default_nettype wire

### sv/euclidean_distance_stream.sv
`default_nettype none
// ----------------------------------------------------------------------------
// euclidean_distance_stream
// Streaming Euclidean distance of two Q8.8 matrices with a square-root chain.
// ----------------------------------------------------------------------------
// Element pairs are taken one per cycle whenever the result side is not
// stalled. Three front stages form the difference, its square and the
// saturating running sum; the pair marked last hands the sum to a chain of
// ROOT_WIDTH square-root cells (24 for a 48-bit sum), one root bit per cell,
// and the distance is read from the output of the last cell. The chain is
// pipelined, so a new run may start right behind the last pair. A result
// stalled at the output stalls the whole pipeline.
module euclidean_distance_stream (
  input wire logic  clk,
  input wire logic  rst,
  eds_in_if.sink    in_ch,
  eds_out_if.source out_ch
);

  logic           en;
  eds_pkg::cell_t chain [eds_pkg::ROOT_WIDTH+1];

  logic [eds_pkg::DIST_EXT_WIDTH-1:0] root_ext;
  logic                               clamp;

  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  eds_accum u_accum (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_valid     (in_ch.valid),
    .elem_a       (in_ch.elem_a),
    .elem_b       (in_ch.elem_b),
    .last_element (in_ch.last_element),
    .launch       (chain[0])
  );

  for (genvar i = 0; i < eds_pkg::ROOT_WIDTH; i++) begin : g_cell
    eds_sqrt_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .prev (chain[i]),
      .next (chain[i+1])
    );
  end

  // The root only outgrows the distance field for sums wider than 48 bits.
  always_comb begin
    root_ext = eds_pkg::DIST_EXT_WIDTH'(chain[eds_pkg::ROOT_WIDTH].root);
    clamp    = (root_ext >> eds_pkg::DIST_WIDTH) != '0;
  end

  assign out_ch.valid     = chain[eds_pkg::ROOT_WIDTH].valid;
  assign out_ch.distance  = clamp ? '1 : root_ext[eds_pkg::DIST_WIDTH-1:0];
  assign out_ch.saturated = chain[eds_pkg::ROOT_WIDTH].sat | clamp;

  a_stall_holds_launch: assert property (@(posedge clk) disable iff (rst)
    !en && chain[0].valid |=> chain[0].valid)
    else $error("launched sum lost during a stall");

  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !out_ch.valid)
    else $error("result valid right after reset");

  a_no_invented_result: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.ready |=> !out_ch.valid ||
      $past(chain[eds_pkg::ROOT_WIDTH-1].valid))
    else $error("result appeared without a preceding chain entry");

endmodule
`default_nettype wire
